[hw/rtl/srrw_pkg.sv]
// Shared types, codes and constants of the selective-repeat receive window.
// No dependencies; imported by srrw_front, srrw_back and the top level.
package srrw_pkg;

    localparam int DefBufferDepth = 8;
    localparam int DefPayloadBits = 32;

    localparam logic [3:0] SEQ_FIRST = 4'd1;
    localparam logic [3:0] SEQ_TOP   = 4'd15;

    localparam logic [2:0]  CAPACITY_RESET = 3'd5;
    localparam logic [47:0] PEER_RESET     = 48'd0;

    // command field
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // frame_type field
    localparam logic [1:0] FRAME_DATA  = 2'd0;
    localparam logic [1:0] FRAME_PROBE = 2'd2;

    // result_kind field
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_MSG   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_PEER     = 1'b1;

    typedef enum logic [2:0] {
        OP_DATA  = 3'd0,
        OP_PROBE = 3'd1,
        OP_READ  = 3'd2,
        OP_TICK  = 3'd3,
        OP_NONE  = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] seq;
    } cmd_t;

    function automatic logic [3:0] seq_after(input logic [3:0] s);
        return (s == SEQ_TOP) ? SEQ_FIRST : s + 4'd1;
    endfunction

    function automatic logic [3:0] seq_before(input logic [3:0] s);
        return (s == SEQ_FIRST) ? SEQ_TOP : s - 4'd1;
    endfunction

endpackage

[hw/rtl/srrw_front.sv]
// Front part: classify an accepted request and hold it in a two-entry queue.
// Depends on srrw_pkg.
module srrw_front #(
    parameter int PAYLOAD_BITS = srrw_pkg::DefPayloadBits
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  logic [1:0]              frame_type,
    input  logic [3:0]              frame_seq,
    input  logic [PAYLOAD_BITS-1:0] frame_payload,
    input  logic [47:0]             source_address,
    input  logic [47:0]             peer_address,
    output logic                    head_valid,
    output srrw_pkg::cmd_t          head_cmd,
    output logic [PAYLOAD_BITS-1:0] head_payload,
    input  logic                    pop
);
    import srrw_pkg::*;

    cmd_t                    cmd_q [2];
    logic [PAYLOAD_BITS-1:0] pay_q [2];
    logic                    wr_ptr_reg;
    logic                    rd_ptr_reg;
    logic [1:0]              count_reg;
    op_t                     op;
    logic                    push;

    // drop foreign frames, acks and unknown codes here
    always_comb
    begin
        op = OP_NONE;
        unique case (command)
            CMD_FRAME:
            begin
                if (source_address == peer_address)
                begin
                    if (frame_type == FRAME_DATA)
                        op = OP_DATA;
                    else if (frame_type == FRAME_PROBE)
                        op = OP_PROBE;
                end
            end
            CMD_READ: op = OP_READ;
            CMD_TICK: op = OP_TICK;
            default:  op = OP_NONE;
        endcase
    end

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy && (op != OP_NONE);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd     = cmd_q[rd_ptr_reg];
    assign head_payload = pay_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_q[wr_ptr_reg] <= '{op: op, seq: frame_seq};
            pay_q[wr_ptr_reg] <= frame_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

[hw/rtl/srrw_back.sv]
// Back part: window state, slot buffer and the slot walks; drives results.
// Depends on srrw_pkg.
module srrw_back #(
    parameter int BUFFER_DEPTH = srrw_pkg::DefBufferDepth,
    parameter int PAYLOAD_BITS = srrw_pkg::DefPayloadBits
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [2:0]              window_capacity,
    input  logic                    head_valid,
    input  srrw_pkg::cmd_t          head_cmd,
    input  logic [PAYLOAD_BITS-1:0] head_payload,
    output logic                    pop,
    output logic                    result_valid,
    output logic [1:0]              result_kind,
    output logic [3:0]              ack_seq,
    output logic [2:0]              ack_window,
    output logic [PAYLOAD_BITS-1:0] message_out
);
    import srrw_pkg::*;

    localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int KW = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_SEARCH = 3'b100
    } state_t;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == IW'(BUFFER_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    logic [PAYLOAD_BITS-1:0] slot_payload [BUFFER_DEPTH];
    logic [3:0]              slot_seq_reg [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] slot_full_reg;

    state_t     state_reg, state_next;
    logic [IW-1:0] wi_reg, wi_next, ri_reg, ri_next;
    logic [IW-1:0] pos_reg, pos_next, idx_reg, idx_next;
    logic [3:0] ne_reg, ne_next, rc_reg, rc_next;
    logic [2:0] fw_reg, fw_next;
    logic       ns_reg, ns_next;
    logic [3:0] last_reg, last_next, e_reg, e_next, cur_seq_reg, cur_seq_next;
    logic [KW-1:0] scan_k_reg, scan_k_next;
    logic [2:0] srch_k_reg, srch_k_next;
    logic [PAYLOAD_BITS-1:0] cur_pay_reg;

    logic       rv_next;
    logic [1:0] kind_next, kind_reg;
    logic [3:0] aseq_next, aseq_reg;
    logic [2:0] awin_next, awin_reg;
    logic       rv_reg;
    logic [PAYLOAD_BITS-1:0] msg_reg;

    logic                    store_en, read_en;
    logic [IW-1:0]           store_idx;
    logic [3:0]              store_seq;
    logic [PAYLOAD_BITS-1:0] store_data;

    always_comb
    begin
        state_next   = state_reg;
        wi_next      = wi_reg;
        ri_next      = ri_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        ne_next      = ne_reg;
        rc_next      = rc_reg;
        fw_next      = fw_reg;
        ns_next      = ns_reg;
        last_next    = last_reg;
        e_next       = e_reg;
        cur_seq_next = cur_seq_reg;
        scan_k_next  = scan_k_reg;
        srch_k_next  = srch_k_reg;
        rv_next      = 1'b0;
        kind_next    = KIND_ACK;
        aseq_next    = 4'd0;
        awin_next    = 3'd0;
        pop          = 1'b0;
        store_en     = 1'b0;
        read_en      = 1'b0;
        store_idx    = wi_reg;
        store_seq    = head_cmd.seq;
        store_data   = head_payload;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    unique case (head_cmd.op)
                        OP_DATA:
                        begin
                            cur_seq_next = head_cmd.seq;
                            if (head_cmd.seq == ne_reg && fw_reg != 3'd0)
                            begin
                                store_en    = 1'b1;
                                fw_next     = fw_reg - 3'd1;
                                if (rc_reg != 4'd15)
                                    rc_next = rc_reg + 4'd1;
                                if (fw_reg == 3'd1)
                                    ns_next = 1'b1;
                                last_next   = head_cmd.seq;
                                idx_next    = wi_reg;
                                pos_next    = idx_inc(wi_reg);
                                scan_k_next = KW'(1);
                                state_next  = ST_SCAN;
                            end
                            else
                            begin
                                e_next      = ne_reg;
                                pos_next    = wi_reg;
                                srch_k_next = 3'd0;
                                state_next  = ST_SEARCH;
                            end
                        end
                        OP_PROBE:
                        begin
                            rv_next   = 1'b1;
                            aseq_next = head_cmd.seq;
                            awin_next = fw_reg;
                        end
                        OP_READ:
                        begin
                            rv_next = 1'b1;
                            if (rc_reg == 4'd0)
                                kind_next = KIND_EMPTY;
                            else
                            begin
                                kind_next = KIND_MSG;
                                read_en   = 1'b1;
                                ri_next   = idx_inc(ri_reg);
                                rc_next   = rc_reg - 4'd1;
                                if (fw_reg < window_capacity)
                                    fw_next = fw_reg + 3'd1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (ns_reg && fw_reg != 3'd0)
                            begin
                                rv_next   = 1'b1;
                                aseq_next = seq_before(ne_reg);
                                awin_next = fw_reg;
                                ns_next   = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // absorb buffered slots while their numbers run on
                if (scan_k_reg == KW'(BUFFER_DEPTH) || fw_reg == 3'd0
                    || !slot_full_reg[pos_reg]
                    || slot_seq_reg[pos_reg] != seq_after(last_reg))
                begin
                    wi_next    = idx_inc(idx_reg);
                    ne_next    = seq_after(last_reg);
                    rv_next    = 1'b1;
                    aseq_next  = last_reg;
                    awin_next  = fw_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    last_next = seq_after(last_reg);
                    idx_next  = pos_reg;
                    fw_next   = fw_reg - 3'd1;
                    if (rc_reg != 4'd15)
                        rc_next = rc_reg + 4'd1;
                    if (fw_reg == 3'd1)
                        ns_next = 1'b1;
                    pos_next    = idx_inc(pos_reg);
                    scan_k_next = scan_k_reg + 1'b1;
                end
            end
            ST_SEARCH:
            begin
                store_idx  = pos_reg;
                store_seq  = cur_seq_reg;
                store_data = cur_pay_reg;
                if (srch_k_reg >= fw_reg || cur_seq_reg == e_reg)
                begin
                    if (srch_k_reg < fw_reg
                        && !(slot_full_reg[pos_reg] && slot_seq_reg[pos_reg] == cur_seq_reg))
                        store_en = 1'b1;
                    rv_next    = 1'b1;
                    aseq_next  = seq_before(ne_reg);
                    awin_next  = fw_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    e_next      = seq_after(e_reg);
                    pos_next    = idx_inc(pos_reg);
                    srch_k_next = srch_k_reg + 3'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // payload buffer, registered read straight into the result register
    always_ff @(posedge clk)
    begin
        if (store_en)
            slot_payload[store_idx] <= store_data;
        msg_reg <= read_en ? slot_payload[ri_reg] : '0;
        if (pop)
            cur_pay_reg <= head_payload;
        kind_reg <= kind_next;
        aseq_reg <= aseq_next;
        awin_reg <= awin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_full_reg <= '0;
            for (int i = 0; i < BUFFER_DEPTH; i++)
                slot_seq_reg[i] <= 4'd0;
            wi_reg      <= '0;
            ri_reg      <= '0;
            pos_reg     <= '0;
            idx_reg     <= '0;
            ne_reg      <= SEQ_FIRST;
            rc_reg      <= 4'd0;
            fw_reg      <= CAPACITY_RESET;
            ns_reg      <= 1'b0;
            last_reg    <= 4'd0;
            e_reg       <= 4'd0;
            cur_seq_reg <= 4'd0;
            scan_k_reg  <= '0;
            srch_k_reg  <= 3'd0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store_en)
            begin
                slot_full_reg[store_idx] <= 1'b1;
                slot_seq_reg[store_idx]  <= store_seq;
            end
            if (read_en)
                slot_full_reg[ri_reg] <= 1'b0;
            wi_reg      <= wi_next;
            ri_reg      <= ri_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            ne_reg      <= ne_next;
            rc_reg      <= rc_next;
            fw_reg      <= fw_next;
            ns_reg      <= ns_next;
            last_reg    <= last_next;
            e_reg       <= e_next;
            cur_seq_reg <= cur_seq_next;
            scan_k_reg  <= scan_k_next;
            srch_k_reg  <= srch_k_next;
            rv_reg      <= rv_next;
        end
    end

    assign result_valid = rv_reg;
    assign result_kind  = kind_reg;
    assign ack_seq      = aseq_reg;
    assign ack_window   = awin_reg;
    assign message_out  = msg_reg;

    a_nospace_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ns_reg) |-> fw_reg == 3'd0)
        else $error("no_space set while window open");

    a_msg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && kind_reg == KIND_MSG) |-> (aseq_reg == 4'd0 && awin_reg == 3'd0))
        else $error("message result carries ack fields");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> srch_k_reg <= fw_reg)
        else $error("search ran past the window");

    a_scan_acks: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_SCAN && state_reg == ST_IDLE) |-> rv_reg)
        else $error("scan ended without an ack");

endmodule

[hw/rtl/selective_repeat_receive_window.sv]
// Top level of the selective-repeat receive window: configuration registers
// and the front/back pair. Depends on srrw_pkg, srrw_front and srrw_back.
//
// Use: raise start with command and frame fields; the request is taken at a
// rising edge where start is high and busy is low. busy rises only when the
// two-entry request queue between front and back is full. Foreign frames,
// ack frames and unknown codes are dropped in the front and never queued.
// Each result (ACK, delivered message, or empty read) shows on result_kind,
// ack_seq, ack_window and message_out for exactly one cycle with
// result_valid high; the receiver cannot stall, so no result ever waits.
// Order: a probe, read or tick is queued in the front and answered from the
// back's result registers. An in-order data frame is stored and then scans on
// through absorbed buffered slots; an out-of-order frame runs the in-window
// search over the slots. The back walks one slot a cycle and handles one
// request at a time.
// Configuration: cfg_write with cfg_index (0 window_capacity, 1 peer_address)
// and cfg_data, to be written by the user only while idle; the block does not enforce it.
// Reset empties all slots, sets the expected sequence to 1 and the free window to 5; no clearing pass is needed.
module selective_repeat_receive_window #(
    parameter int BUFFER_DEPTH = srrw_pkg::DefBufferDepth,
    parameter int PAYLOAD_BITS = srrw_pkg::DefPayloadBits
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [47:0]             cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  logic [1:0]              frame_type,
    input  logic [3:0]              frame_seq,
    input  logic [PAYLOAD_BITS-1:0] frame_payload,
    input  logic [47:0]             source_address,
    output logic                    result_valid,
    output logic [1:0]              result_kind,
    output logic [3:0]              ack_seq,
    output logic [2:0]              ack_window,
    output logic [PAYLOAD_BITS-1:0] message_out
);
    import srrw_pkg::*;

    logic [2:0]              capacity_reg;
    logic [47:0]             peer_reg;
    logic                    head_valid;
    cmd_t                    head_cmd;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic                    pop;

    // hold configuration; the user writes only while the block is idle, which it does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            peer_reg     <= PEER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: capacity_reg <= cfg_data[2:0];
                CFG_PEER:     peer_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // classify and queue requests
    srrw_front #(
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .frame_type    (frame_type),
        .frame_seq     (frame_seq),
        .frame_payload (frame_payload),
        .source_address(source_address),
        .peer_address  (peer_reg),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_payload  (head_payload),
        .pop           (pop)
    );

    // carry out requests against the window and slot buffer
    srrw_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_capacity(capacity_reg),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .head_payload   (head_payload),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_kind    (result_kind),
        .ack_seq        (ack_seq),
        .ack_window     (ack_window),
        .message_out    (message_out)
    );

endmodule
